// File: hw/rtl/lpdf_pkg.sv
// Shared widths and register indexes for the linear-probe duplicate filter.
package lpdf_pkg;

    localparam int HASH_W   = 64;
    localparam int HALF_W   = 32;
    localparam int FP_W     = 32;
    localparam int TSIZE_W  = 17;
    localparam int SLOT_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_B     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;

    localparam logic [HASH_W-1:0]  MULT_RESET       = 64'd1;
    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RESET = 17'd65521;

endpackage

// File: hw/rtl/lpdf_hash.sv
// 64-bit hash h = mult_a*a + mult_b*b mod 2^64 on one shared 32x32 multiplier.
module lpdf_hash (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lpdf_pkg::HASH_W-1:0]  rel_a,
    input  logic [lpdf_pkg::HASH_W-1:0]  rel_b,
    input  logic [lpdf_pkg::HASH_W-1:0]  mult_a,
    input  logic [lpdf_pkg::HASH_W-1:0]  mult_b,
    output logic                         done,
    output logic [lpdf_pkg::HASH_W-1:0]  hash
);
    import lpdf_pkg::*;

    // Six partial products: lo*lo full, lo*hi and hi*lo only in the upper half.
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic [2:0]        step_reg;
    logic              busy_reg;
    logic [HASH_W-1:0] prod_reg;
    logic              prod_vld_reg;
    logic              prod_full_reg;
    logic              prod_last_reg;
    logic [HASH_W-1:0] acc_reg;
    logic              done_reg;

    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [HASH_W-1:0] addend;

    always_comb begin
        case (step_reg)
            3'd0: begin op_x = rel_a[HALF_W-1:0];      op_y = mult_a[HALF_W-1:0];      end
            3'd1: begin op_x = rel_a[HALF_W-1:0];      op_y = mult_a[HASH_W-1:HALF_W]; end
            3'd2: begin op_x = rel_a[HASH_W-1:HALF_W]; op_y = mult_a[HALF_W-1:0];      end
            3'd3: begin op_x = rel_b[HALF_W-1:0];      op_y = mult_b[HALF_W-1:0];      end
            3'd4: begin op_x = rel_b[HALF_W-1:0];      op_y = mult_b[HASH_W-1:HALF_W]; end
            3'd5: begin op_x = rel_b[HASH_W-1:HALF_W]; op_y = mult_b[HALF_W-1:0];      end
            default: begin op_x = '0; op_y = '0; end
        endcase
    end

    assign addend = prod_full_reg ? prod_reg : {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            busy_reg     <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg     <= prod_vld_reg && prod_last_reg;
            prod_vld_reg <= busy_reg;
            if (start) begin
                step_reg <= '0;
                busy_reg <= 1'b1;
                acc_reg  <= '0;
            end else begin
                if (busy_reg) begin
                    prod_reg      <= HASH_W'(op_x) * HASH_W'(op_y);
                    prod_full_reg <= (step_reg == 3'd0) || (step_reg == 3'd3);
                    prod_last_reg <= (step_reg == LAST_STEP);
                    step_reg      <= step_reg + 3'd1;
                    if (step_reg == LAST_STEP) begin
                        busy_reg <= 1'b0;
                    end
                end
                if (prod_vld_reg) begin
                    acc_reg <= acc_reg + addend;
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = acc_reg;

endmodule

// File: hw/rtl/lpdf_mod.sv
// Bit-serial remainder of the 64-bit hash by the slot count, one bit per cycle.
module lpdf_mod #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [lpdf_pkg::HASH_W-1:0]           dividend,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      divisor,
    output logic                                  done,
    output logic [$clog2(TABLE_DEPTH)-1:0]        remainder
);
    import lpdf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(HASH_W);

    logic [HASH_W-1:0] div_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [IDX_W:0] trial;
    logic [IDX_W:0] dsr_ext;
    logic [IDX_W:0] diff;

    // Remainder stays below the divisor, so one compare-subtract per bit suffices.
    assign trial   = {rem_reg, div_reg[HASH_W-1]};
    assign dsr_ext = (IDX_W+1)'(divisor);
    assign diff    = trial - dsr_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                div_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(HASH_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                div_reg <= {div_reg[HASH_W-2:0], 1'b0};
                rem_reg <= (trial >= dsr_ext) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/lpdf_table.sv
// Fingerprint store with one write port and one read port, registered read data.
module lpdf_table #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
    input  logic [lpdf_pkg::FP_W-1:0]         wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
    output logic [lpdf_pkg::FP_W-1:0]         rd_data
);
    import lpdf_pkg::*;

    logic [FP_W-1:0] mem [TABLE_DEPTH];
    logic [FP_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/linear_probe_duplicate_filter_core.sv
// Top level: hashes (rel_a, rel_b) pairs and filters duplicates in a linear-probe table.
//
// Input stream s_*: one pair per request, rel_a in s_tdata[63:0], rel_b in s_tdata[127:64].
// Output stream m_*: one result per input request, is_duplicate, slot and probe_count
// in m_tdata, table_full in m_tuser. Config channel cfg_*: index 0 mult_a, 1 mult_b,
// 2 table_size; cfg_ready is always high and writes belong between requests.
// One request at a time: s_tready is high only while the block is idle. From accept
// to m_tvalid a request passes the hash on the shared 32x32 multiplier, the
// bit-serial remainder and its handoff, a read state and a check state per probed
// slot (address, then registered read and compare) and the load of the output
// register. s_tready rises with m_tvalid, so the next request is taken only once
// the last one has reached the output register.
// A finished result sits in the output register, so the next request is taken
// while the receiver stalls; a further result waits until that register drains.
// After aresetn the table is swept to zero one slot per cycle with s_tready low;
// config writes are taken during the sweep.
module linear_probe_duplicate_filter_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpdf_pkg::S_DATA_W-1:0]     s_tdata,   // rel_a[63:0], rel_b[127:64]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpdf_pkg::M_DATA_W-1:0]     m_tdata,   // is_duplicate[0], slot[16:1],
                                                         // probe_count[32:17], zero[39:33]
    output logic [lpdf_pkg::M_USER_W-1:0]     m_tuser,   // table_full[0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lpdf_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SZ_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (SZ_W > TSIZE_W) ? SZ_W : TSIZE_W;
    localparam int SLOT_XW = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CNT_XW  = (SZ_W > COUNT_W) ? SZ_W : COUNT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_RESULT
    } state_t;

    state_t state_reg;

    logic [HASH_W-1:0]  mult_a_reg;
    logic [HASH_W-1:0]  mult_b_reg;
    logic [TSIZE_W-1:0] table_size_reg;

    logic [HASH_W-1:0] rel_a_reg;
    logic [HASH_W-1:0] rel_b_reg;
    logic [SZ_W-1:0]   size_reg;
    logic [FP_W-1:0]   fp_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SZ_W-1:0]   steps_reg;
    logic [IDX_W-1:0]  clr_addr_reg;

    logic               res_dup_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_full_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic s_accept;
    logic cfg_accept;
    logic res_load;

    logic [CMP_W-1:0] ts_ext;
    logic [CMP_W-1:0] eff_size;

    logic              hash_start;
    logic              hash_done;
    logic [HASH_W-1:0] hash_val;
    logic              mod_start;
    logic              mod_done;
    logic [IDX_W-1:0]  mod_rem;

    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    logic [FP_W-1:0]   tbl_wr_data;
    logic              tbl_rd_en;
    logic [FP_W-1:0]   tbl_rd_data;

    logic             hit_match;
    logic             hit_empty;
    logic [SZ_W-1:0]  steps_inc;
    logic [IDX_W:0]   idx_inc;
    logic [IDX_W-1:0] idx_wrap;
    logic [SLOT_XW-1:0] slot_wide;
    logic [CNT_XW-1:0]  count_wide;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign res_load   = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // Slot count in use: zero acts as one, anything past the memory as its depth.
    always_comb begin
        ts_ext = CMP_W'(table_size_reg);
        if (ts_ext == '0) begin
            eff_size = CMP_W'(1);
        end else if (ts_ext > DEPTH_C) begin
            eff_size = DEPTH_C;
        end else begin
            eff_size = ts_ext;
        end
    end

    assign hash_start = s_accept;
    assign mod_start  = (state_reg == ST_HASH) && hash_done;

    assign hit_match = (tbl_rd_data == fp_reg);
    assign hit_empty = (tbl_rd_data == '0);
    assign steps_inc = steps_reg + SZ_W'(1);
    assign idx_inc   = (IDX_W+1)'(idx_reg) + (IDX_W+1)'(1);
    assign idx_wrap  = (idx_inc == (IDX_W+1)'(size_reg)) ? '0 : idx_inc[IDX_W-1:0];
    assign slot_wide  = SLOT_XW'(idx_reg);
    assign count_wide = CNT_XW'(steps_reg);

    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = idx_reg;
        tbl_wr_data = fp_reg;
        if (state_reg == ST_CLEAR) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_addr_reg;
            tbl_wr_data = '0;
        end else if (state_reg == ST_CHECK && hit_empty && !hit_match) begin
            tbl_wr_en = 1'b1;
        end
    end

    assign tbl_rd_en = (state_reg == ST_READ);

    lpdf_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .rel_a   (rel_a_reg),
        .rel_b   (rel_b_reg),
        .mult_a  (mult_a_reg),
        .mult_b  (mult_b_reg),
        .done    (hash_done),
        .hash    (hash_val)
    );

    lpdf_mod #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (hash_val),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lpdf_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (idx_reg),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            mult_a_reg     <= MULT_RESET;
            mult_b_reg     <= MULT_RESET;
            table_size_reg <= TABLE_SIZE_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_accept) begin
                unique case (cfg_index)
                    CFG_MULT_A:     mult_a_reg     <= cfg_data;
                    CFG_MULT_B:     mult_b_reg     <= cfg_data;
                    CFG_TABLE_SIZE: table_size_reg <= cfg_data[TSIZE_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !res_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        rel_a_reg <= s_tdata[HASH_W-1:0];
                        rel_b_reg <= s_tdata[S_DATA_W-1:HASH_W];
                        size_reg  <= eff_size[SZ_W-1:0];
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (hash_done) begin
                        fp_reg    <= hash_val[HASH_W-1:HASH_W-FP_W];
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        idx_reg   <= mod_rem;
                        steps_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (hit_match || hit_empty) begin
                        res_dup_reg   <= hit_match;
                        res_slot_reg  <= slot_wide[SLOT_W-1:0];
                        res_count_reg <= count_wide[COUNT_W-1:0];
                        res_full_reg  <= 1'b0;
                        state_reg     <= ST_RESULT;
                    end else if (steps_inc == size_reg) begin
                        // every slot in use probed once with no room
                        res_dup_reg   <= 1'b0;
                        res_slot_reg  <= '0;
                        res_count_reg <= '0;
                        res_full_reg  <= 1'b1;
                        state_reg     <= ST_RESULT;
                    end else begin
                        steps_reg <= steps_inc;
                        idx_reg   <= idx_wrap;
                        state_reg <= ST_READ;
                    end
                end
                ST_RESULT: begin
                    if (res_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_DATA_W'({res_count_reg, res_slot_reg, res_dup_reg});
                        m_tuser_reg  <= M_USER_W'(res_full_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the linear-probe duplicate filter core.
`timescale 1ns / 1ps

import lpdf_pkg::*;

localparam int FILTER_DEPTH = 65536;

typedef struct packed {
    logic               is_duplicate;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] probe_count;
    logic               table_full;
} probe_verdict_t;

class dedup_scoreboard;
    bit [FP_W-1:0]    fp_table [FILTER_DEPTH];
    bit [HASH_W-1:0]  mult_a = MULT_RESET;
    bit [HASH_W-1:0]  mult_b = MULT_RESET;
    bit [TSIZE_W-1:0] table_size = TABLE_SIZE_RESET;
    probe_verdict_t   verdicts_due[$];
    int               failures = 0;

    function int unsigned slots_in_use();
        int unsigned n;
        n = table_size;
        if (n == 0)
            n = 1;
        if (n > FILTER_DEPTH)
            n = FILTER_DEPTH;
        return n;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MULT_A:     mult_a = data;
            CFG_MULT_B:     mult_b = data;
            CFG_TABLE_SIZE: table_size = data[TSIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // Walk the table from the home slot; store the fingerprint on a fresh hit.
    function probe_verdict_t probe_and_insert(bit [63:0] rel_a, bit [63:0] rel_b);
        probe_verdict_t v;
        bit [HASH_W-1:0] h;
        bit [FP_W-1:0]   fp;
        int unsigned     n, idx, steps;
        n = slots_in_use();
        h = mult_a * rel_a + mult_b * rel_b;
        idx = int'(h % 64'(n));
        fp = h[63:32];
        steps = 0;
        while (steps < n && fp_table[idx] != 0 && fp_table[idx] != fp) begin
            steps++;
            idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        v = '0;
        if (steps >= n) begin
            v.table_full = 1'b1;
        end else begin
            // a zero fingerprint looks like an empty slot and reads as a duplicate
            v.is_duplicate = (fp_table[idx] == fp);
            if (!v.is_duplicate)
                fp_table[idx] = fp;
            v.slot = idx[SLOT_W-1:0];
            v.probe_count = steps[COUNT_W-1:0];
        end
        return v;
    endfunction

    function void note_pair(bit [63:0] rel_a, bit [63:0] rel_b);
        verdicts_due.push_back(probe_and_insert(rel_a, rel_b));
    endfunction

    function void check_verdict(probe_verdict_t got);
        probe_verdict_t want;
        if (verdicts_due.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: dup=%0d slot=%0d probes=%0d full=%0d",
                         got.is_duplicate, got.slot, got.probe_count, got.table_full);
            return;
        end
        want = verdicts_due.pop_front();
        if (got.is_duplicate != want.is_duplicate || got.slot != want.slot ||
            got.probe_count != want.probe_count || got.table_full != want.table_full) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: exp dup/slot/probes/full %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         want.is_duplicate, want.slot, want.probe_count, want.table_full,
                         got.is_duplicate, got.slot, got.probe_count, got.table_full);
        end
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 600000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MULT_A;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dedup_scoreboard sb;
    bit [127:0]      seen_pairs[$];
    int unsigned     hot_slot = 0;
    bit              no_gaps = 1'b0;
    int              sink_stall = 0;
    int              idle_cycles = 0;

    linear_probe_duplicate_filter_core #(
        .TABLE_DEPTH(FILTER_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #6;
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
    end

    // result sink: mostly ready, short and long stalls unless in a quiet phase
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_gaps) begin
                case ($urandom_range(0, 99)) inside
                    [0:9]:   sink_stall = $urandom_range(1, 3);
                    [10:11]: sink_stall = $urandom_range(20, 100);
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_verdict({m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tuser[0]});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pair(input bit [63:0] rel_a, input bit [63:0] rel_b);
        int gap;
        s_tdata <= {rel_b, rel_a};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_pair(rel_a, rel_b);
        gap = 0;
        if (!no_gaps) begin
            case ($urandom_range(0, 99)) inside
                [0:21]:  gap = $urandom_range(1, 3);
                [22:24]: gap = $urandom_range(20, 150);
                default: ;
            endcase
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic load_registers(input bit [63:0] ma, input bit [63:0] mb,
                                  input bit [63:0] size_word);
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: begin
                    cfg_index <= CFG_MULT_A;
                    cfg_data <= ma;
                end
                1: begin
                    cfg_index <= CFG_MULT_B;
                    cfg_data <= mb;
                end
                default: begin
                    cfg_index <= CFG_TABLE_SIZE;
                    cfg_data <= size_word;
                end
            endcase
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            sb.write_reg(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly repeats of recent pairs and hashes steered onto crowded slots,
    // the rest random or extreme values.
    function automatic void pick_pair(output bit [63:0] rel_a, output bit [63:0] rel_b);
        int unsigned n, r, back;
        bit [63:0]   h;
        n = sb.slots_in_use();
        r = $urandom_range(0, 99);
        rel_a = {$urandom, $urandom};
        rel_b = {$urandom, $urandom};
        if (r < 35 && seen_pairs.size() > 0) begin
            back = (seen_pairs.size() < 48) ? seen_pairs.size() : 48;
            {rel_b, rel_a} = seen_pairs[seen_pairs.size() - 1 - $urandom_range(0, back - 1)];
            return;
        end else if (r < 75 && sb.mult_b == 1) begin
            h = {$urandom, $urandom};
            if (r >= 70)
                h[63:32] = '0;
            case ($urandom_range(0, 3))
                0: h = h - h % n + (n - 1);
                1: h = h - h % n + ((n > 1) ? n - 2 : 0);
                2: h = h - h % n + hot_slot;
                default: ;
            endcase
            rel_b = h - sb.mult_a * rel_a;
        end else if (r < 80) begin
            rel_a = '0;
            rel_b = '0;
        end else if (r < 88) begin
            case ($urandom_range(0, 3))
                0: rel_a = 64'h8000_0000_0000_0000;
                1: rel_a = 64'h7FFF_FFFF_FFFF_FFFF;
                2: rel_a = '0;
                default: rel_a = '1;
            endcase
            case ($urandom_range(0, 2))
                0: rel_b = '0;
                1: rel_b = '1;
                default: rel_b = 64'd1;
            endcase
        end
        seen_pairs.push_back({rel_b, rel_a});
        if (seen_pairs.size() > 256)
            void'(seen_pairs.pop_front());
    endfunction

    task automatic wait_drained();
        while (sb.verdicts_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input bit [63:0] ma, input bit [63:0] mb,
                             input bit [63:0] size_word, input int count, input bit quiet);
        bit [63:0] rel_a, rel_b;
        load_registers(ma, mb, size_word);
        hot_slot = $urandom_range(0, sb.slots_in_use() - 1);
        no_gaps = quiet;
        for (int i = 0; i < count; i++) begin
            pick_pair(rel_a, rel_b);
            send_pair(rel_a, rel_b);
        end
        s_tvalid <= 1'b0;
        wait_drained();
        no_gaps = 1'b0;
    endtask

    initial begin
        bit [63:0]   h;
        int unsigned n;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: hash is rel_a + rel_b
        send_pair(64'd0, 64'd0);
        send_pair(64'h1_0000_0000, 64'd0);
        send_pair(64'h1_0000_0000, 64'd0);
        send_pair(64'd0, 64'h1_0000_0000);
        send_pair(64'h8000_0000_0000_0000, 64'd0);
        send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
        send_pair(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        // chain on the last slot, wrapping to slot 0
        n = sb.slots_in_use();
        for (int k = 5; k < 9; k++) begin
            h = 64'(k) << 32;
            send_pair(64'd0, h - h % n + (n - 1));
        end
        h = 64'd6 << 32;
        send_pair(64'd0, h - h % n + (n - 1));
        s_tvalid <= 1'b0;
        wait_drained();

        run_phase(64'd1, 64'd1, 64'd65521, 200, 1'b0);
        run_phase('1, 64'd1, 64'd7, 150, 1'b0);
        run_phase({$urandom, $urandom} | 64'd1, {$urandom, $urandom}, 64'd1, 80, 1'b0);
        run_phase(64'd0, '1, 64'd0, 80, 1'b0);
        run_phase({$urandom, $urandom}, 64'd1, 64'hFFFF_FFFF_FFFE_000D, 150, 1'b0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'd65536, 200, 1'b1);
        run_phase({$urandom, $urandom}, 64'd1, 64'd131071, 200, 1'b0);
        run_phase(64'd0, 64'd0, 64'd2, 30, 1'b0);
        run_phase(64'h8000_0000_0000_0000, 64'd1, 64'd61, 200, 1'b0);
        run_phase({$urandom, $urandom}, 64'd1, 64'd31, 150, 1'b1);
        run_phase({$urandom, $urandom}, 64'd1, 64'd65521, 220, 1'b0);

        repeat (200) @(posedge aclk);
        if (sb.failures == 0 && sb.verdicts_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
